FILE: rtl/pfhv_pkg.sv
// Package: shared types and constants for the PSF font header validator.
`timescale 1ns / 1ps
`default_nettype none

package pfhv_pkg;

  localparam logic [15:0] PSF1_MAGIC           = 16'h0436;
  localparam logic [31:0] PSF2_MAGIC           = 32'h864AB572;
  localparam logic [7:0]  PSF1_MAX_ROWS        = 8'd32;
  localparam logic [31:0] PSF2_MAX_GLYPHS      = 32'h0010_0000;
  localparam logic [31:0] PSF2_MAX_GLYPH_BYTES = 32'd1024;
  localparam logic [31:0] PSF2_MAX_DIM         = 32'd256;
  localparam logic [31:0] PSF2_HEADER_MIN      = 32'd32;
  localparam logic [31:0] FILE_MIN             = 32'd4;
  localparam logic [31:0] PSF1_GLYPH_BASE      = 32'd4;
  localparam logic [8:0]  PSF1_WIDTH           = 9'd8;
  localparam logic [7:0]  MODE_512             = 8'h01;
  localparam logic [7:0]  MODE_TAB             = 8'h02;
  localparam logic [7:0]  MODE_SEQ             = 8'h04;
  localparam logic [31:0] FLAG_UNICODE         = 32'h0000_0001;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_PSF1 = 2'd1,
    FMT_PSF2 = 2'd2
  } fmt_t;

  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] header_length;
    logic [31:0] flag_word;
    logic [31:0] glyph_total;
    logic [31:0] bytes_per_glyph;
    logic [31:0] pixel_rows;
    logic [31:0] pixel_columns;
    logic [31:0] file_length;
  } hdr_t;

  typedef struct packed {
    logic        pass;
    fmt_t        ver;
    logic [20:0] gc;
    logic [10:0] gs;
    logic [8:0]  wpx;
    logic [8:0]  hpx;
    logic [31:0] base;
    logic [30:0] area;
    logic        map;
    logic [31:0] flen;
  } geom_t;

  typedef struct packed {
    logic        valid_res;
    fmt_t        format_version;
    logic [20:0] glyph_num;
    logic [10:0] glyph_size;
    logic [8:0]  glyph_width;
    logic [8:0]  glyph_height;
    logic [31:0] glyph_base;
    logic [30:0] glyph_area;
    logic        has_map;
    logic [31:0] map_base;
    logic [31:0] map_length;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/pfhv_if.sv
// Interfaces: header input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none

interface pfhv_hdr_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_word;
  logic [31:0] header_length;
  logic [31:0] flag_word;
  logic [31:0] glyph_total;
  logic [31:0] bytes_per_glyph;
  logic [31:0] pixel_rows;
  logic [31:0] pixel_columns;
  logic [31:0] file_length;

  modport source (
    output valid, first_word, header_length, flag_word, glyph_total,
           bytes_per_glyph, pixel_rows, pixel_columns, file_length,
    input  ready
  );
  modport sink (
    input  valid, first_word, header_length, flag_word, glyph_total,
           bytes_per_glyph, pixel_rows, pixel_columns, file_length,
    output ready
  );
endinterface

interface pfhv_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [1:0]  format_version;
  logic [20:0] glyph_num;
  logic [10:0] glyph_size;
  logic [8:0]  glyph_width;
  logic [8:0]  glyph_height;
  logic [31:0] glyph_base;
  logic [30:0] glyph_area;
  logic        has_map;
  logic [31:0] map_base;
  logic [31:0] map_length;

  modport source (
    output valid, valid_res, format_version, glyph_num, glyph_size, glyph_width,
           glyph_height, glyph_base, glyph_area, has_map, map_base, map_length,
    input  ready
  );
  modport sink (
    input  valid, valid_res, format_version, glyph_num, glyph_size, glyph_width,
           glyph_height, glyph_base, glyph_area, has_map, map_base, map_length,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/pfhv_capture.sv
// Input register stage: captures one header item per accepted handshake.
`timescale 1ns / 1ps
`default_nettype none

module pfhv_capture (
  input  wire logic          clk,
  input  wire logic          rst,
  pfhv_hdr_if.sink           hdr,
  output logic               valid,
  input  wire logic          ready,
  output pfhv_pkg::hdr_t     data
);

  logic take;

  assign take      = !valid || ready;
  assign hdr.ready = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= hdr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hdr.valid) begin
      data.first_word      <= hdr.first_word;
      data.header_length   <= hdr.header_length;
      data.flag_word       <= hdr.flag_word;
      data.glyph_total     <= hdr.glyph_total;
      data.bytes_per_glyph <= hdr.bytes_per_glyph;
      data.pixel_rows      <= hdr.pixel_rows;
      data.pixel_columns   <= hdr.pixel_columns;
      data.file_length     <= hdr.file_length;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pfhv_decode.sv
// Decode stage: magic and range checks, geometry multiplies, registered.
`timescale 1ns / 1ps
`default_nettype none

module pfhv_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pfhv_pkg::hdr_t in_data,
  output logic               valid,
  input  wire logic          ready,
  output pfhv_pkg::geom_t    data
);

  logic            take;
  logic            flen_ok;
  logic            is_psf1;
  logic [7:0]      mode;
  logic [7:0]      rows1;
  logic            p1_ok;
  logic [14:0]     p1_area;
  logic            is_psf2;
  logic [9:0]      cols_up;
  logic [15:0]     row_bytes;
  logic            p2_ok;
  logic [31:0]     p2_area;
  pfhv_pkg::geom_t data_next;

  assign take     = !valid || ready;
  assign in_ready = take;

  assign flen_ok = in_data.file_length >= pfhv_pkg::FILE_MIN;
  assign is_psf1 = in_data.first_word[15:0] == pfhv_pkg::PSF1_MAGIC;
  assign mode    = in_data.first_word[23:16];
  assign rows1   = in_data.first_word[31:24];
  assign p1_ok   = flen_ok && is_psf1 && (rows1 != 8'd0) && (rows1 <= pfhv_pkg::PSF1_MAX_ROWS);
  assign p1_area = ((mode & pfhv_pkg::MODE_512) != 8'd0) ? {rows1[5:0], 9'd0}
                                                         : {1'b0, rows1[5:0], 8'd0};

  assign is_psf2 = flen_ok && !is_psf1 && (in_data.file_length >= pfhv_pkg::PSF2_HEADER_MIN) &&
                   (in_data.first_word == pfhv_pkg::PSF2_MAGIC);
  assign cols_up   = {1'b0, in_data.pixel_columns[8:0]} + 10'd7;
  assign row_bytes = 16'(cols_up[9:3]) * 16'(in_data.pixel_rows[8:0]);
  assign p2_area   = 32'(in_data.glyph_total[20:0]) * 32'(in_data.bytes_per_glyph[10:0]);
  assign p2_ok = is_psf2 &&
                 (in_data.header_length >= pfhv_pkg::PSF2_HEADER_MIN) &&
                 (in_data.header_length <= in_data.file_length) &&
                 (in_data.glyph_total != 32'd0) &&
                 (in_data.glyph_total <= pfhv_pkg::PSF2_MAX_GLYPHS) &&
                 (in_data.bytes_per_glyph != 32'd0) &&
                 (in_data.bytes_per_glyph <= pfhv_pkg::PSF2_MAX_GLYPH_BYTES) &&
                 (in_data.pixel_rows != 32'd0) &&
                 (in_data.pixel_rows <= pfhv_pkg::PSF2_MAX_DIM) &&
                 (in_data.pixel_columns != 32'd0) &&
                 (in_data.pixel_columns <= pfhv_pkg::PSF2_MAX_DIM) &&
                 (in_data.bytes_per_glyph == 32'(row_bytes));

  always_comb begin
    data_next.pass = p1_ok || p2_ok;
    data_next.flen = in_data.file_length;
    if (p1_ok) begin
      data_next.ver  = pfhv_pkg::FMT_PSF1;
      data_next.gc   = ((mode & pfhv_pkg::MODE_512) != 8'd0) ? 21'd512 : 21'd256;
      data_next.gs   = {5'd0, rows1[5:0]};
      data_next.wpx  = pfhv_pkg::PSF1_WIDTH;
      data_next.hpx  = {3'd0, rows1[5:0]};
      data_next.base = pfhv_pkg::PSF1_GLYPH_BASE;
      data_next.area = 31'(p1_area);
      data_next.map  = (mode & (pfhv_pkg::MODE_TAB | pfhv_pkg::MODE_SEQ)) != 8'd0;
    end else begin
      data_next.ver  = p2_ok ? pfhv_pkg::FMT_PSF2 : pfhv_pkg::FMT_NONE;
      data_next.gc   = in_data.glyph_total[20:0];
      data_next.gs   = in_data.bytes_per_glyph[10:0];
      data_next.wpx  = in_data.pixel_columns[8:0];
      data_next.hpx  = in_data.pixel_rows[8:0];
      data_next.base = in_data.header_length;
      data_next.area = p2_area[30:0];
      data_next.map  = (in_data.flag_word & pfhv_pkg::FLAG_UNICODE) != 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pfhv_place.sv
// Placement stage: file fit check, unicode table position, result register.
`timescale 1ns / 1ps
`default_nettype none

module pfhv_place (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pfhv_pkg::geom_t in_data,
  pfhv_res_if.source          res
);

  logic           take;
  logic [32:0]    span;
  logic           fits;
  logic           ok;
  pfhv_pkg::res_t r;
  pfhv_pkg::res_t r_next;

  assign take     = !res.valid || res.ready;
  assign in_ready = take;

  assign span = {1'b0, in_data.base} + {2'b0, in_data.area};
  assign fits = span <= {1'b0, in_data.flen};
  assign ok   = in_data.pass && fits;

  always_comb begin
    r_next = '0;
    if (ok) begin
      r_next.valid_res      = 1'b1;
      r_next.format_version = in_data.ver;
      r_next.glyph_num      = in_data.gc;
      r_next.glyph_size     = in_data.gs;
      r_next.glyph_width    = in_data.wpx;
      r_next.glyph_height   = in_data.hpx;
      r_next.glyph_base     = in_data.base;
      r_next.glyph_area     = in_data.area;
      r_next.has_map        = in_data.map;
      if (in_data.map) begin
        r_next.map_base   = span[31:0];
        r_next.map_length = in_data.flen - span[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      r <= r_next;
    end
  end

  assign res.valid_res      = r.valid_res;
  assign res.format_version = r.format_version;
  assign res.glyph_num      = r.glyph_num;
  assign res.glyph_size     = r.glyph_size;
  assign res.glyph_width    = r.glyph_width;
  assign res.glyph_height   = r.glyph_height;
  assign res.glyph_base     = r.glyph_base;
  assign res.glyph_area     = r.glyph_area;
  assign res.has_map        = r.has_map;
  assign res.map_base       = r.map_base;
  assign res.map_length     = r.map_length;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.valid_res |-> res.format_version == pfhv_pkg::FMT_NONE &&
      res.glyph_num == 21'd0 && res.glyph_base == 32'd0 && !res.has_map &&
      res.map_base == 32'd0 && res.map_length == 32'd0)
    else $error("rejected item carries nonzero fields");

  a_accept_fmt: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.valid_res |-> res.format_version == pfhv_pkg::FMT_PSF1 ||
      res.format_version == pfhv_pkg::FMT_PSF2)
    else $error("accepted item without a format");

  a_map_base: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.has_map |->
      res.map_base == res.glyph_base + 32'(res.glyph_area))
    else $error("map base does not follow glyph data");

  a_psf1_geom: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.format_version == pfhv_pkg::FMT_PSF1 |->
      res.glyph_width == pfhv_pkg::PSF1_WIDTH && res.glyph_size == 11'(res.glyph_height) &&
      (res.glyph_num == 21'd256 || res.glyph_num == 21'd512))
    else $error("PSF1 geometry inconsistent");

endmodule

`default_nettype wire

FILE: rtl/psf_font_header_validator.sv
// Top level: PSF1/PSF2 font header validator.
//
// Channels: hdr takes one font header item (first word, PSF2 header words
// and total file length); res returns one result item per header with the
// accept flag, format, glyph geometry and unicode table placement. Every
// result field, the accept flag included, is zero on a rejected header.
// Both channels use valid/ready; an item moves when both are high.
// An accepted header is loaded first into the input register, then into the decode
// register holding the geometry products, and last into the result register.
// Throughput: one header per cycle while res.ready stays high; the pipeline
// registers and the two narrow multiplies in the decode stage set that figure.
// Reset (rst, synchronous): clears all stage valid flags; no item in flight.
// Receiver stall: a held res.ready freezes the result register; earlier
// stages keep filling until each holds an item, then hdr.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module psf_font_header_validator (
  input  wire logic  clk,
  input  wire logic  rst,
  pfhv_hdr_if.sink   hdr,
  pfhv_res_if.source res
);

  logic            cap_valid;
  logic            cap_ready;
  pfhv_pkg::hdr_t  cap_data;
  logic            dec_valid;
  logic            dec_ready;
  pfhv_pkg::geom_t dec_data;

  pfhv_capture u_capture (
    .clk   (clk),
    .rst   (rst),
    .hdr   (hdr),
    .valid (cap_valid),
    .ready (cap_ready),
    .data  (cap_data)
  );

  pfhv_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cap_valid),
    .in_ready (cap_ready),
    .in_data  (cap_data),
    .valid    (dec_valid),
    .ready    (dec_ready),
    .data     (dec_data)
  );

  pfhv_place u_place (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dec_valid),
    .in_ready (dec_ready),
    .in_data  (dec_data),
    .res      (res)
  );

endmodule

`default_nettype wire
